/* design/qpce_pkg.sv */
// types, constants and the hash function shared by the qoi chunk encoder
`default_nettype none

package qpce_pkg;

  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned INDEX_DEPTH = 64;
  localparam int unsigned CHUNK_BYTES = 5;

  localparam logic [7:0] OP_INDEX = 8'h00;
  localparam logic [7:0] OP_DIFF  = 8'h40;
  localparam logic [7:0] OP_LUMA  = 8'h80;
  localparam logic [7:0] OP_RUN   = 8'hc0;
  localparam logic [7:0] OP_RGB   = 8'hfe;
  localparam logic [7:0] OP_RGBA  = 8'hff;

  localparam logic [5:0] RUN_MAX      = 6'd62;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  // channel count register codes
  localparam logic [2:0] CC_RGB   = 3'd3;
  localparam logic [2:0] CC_RESET = 3'd4;

  // chunk lengths in bytes
  localparam logic [2:0] LEN_NONE  = 3'd0;
  localparam logic [2:0] LEN_INDEX = 3'd1;
  localparam logic [2:0] LEN_DIFF  = 3'd1;
  localparam logic [2:0] LEN_LUMA  = 3'd2;
  localparam logic [2:0] LEN_RGB   = 3'd4;
  localparam logic [2:0] LEN_RGBA  = 3'd5;

  // red in the low byte, alpha in the high byte
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } pixel_t;

  localparam pixel_t PREV_RESET = '{a: 8'hff, b: 8'h00, g: 8'h00, r: 8'h00};

  // one classified pixel: an optional run byte followed by an optional chunk
  typedef struct packed {
    logic                        last;
    logic                        run_valid;
    logic [7:0]                  run_byte;
    logic [2:0]                  chunk_len;
    logic [CHUNK_BYTES-1:0][7:0] chunk;
  } cmd_t;

  // slot = (3r + 5g + 7b + 11a) mod 64, only the low six bits matter
  function automatic logic [SLOT_W-1:0] qpce_hash(input pixel_t p);
    logic [SLOT_W-1:0] h;
    h = SLOT_W'(p.r[SLOT_W-1:0] * SLOT_W'(3)) + SLOT_W'(p.g[SLOT_W-1:0] * SLOT_W'(5))
      + SLOT_W'(p.b[SLOT_W-1:0] * SLOT_W'(7)) + SLOT_W'(p.a[SLOT_W-1:0] * SLOT_W'(11));
    return h;
  endfunction

endpackage

`default_nettype wire

/* design/qpce_if.sv */
// channel interfaces of the qoi chunk encoder: pixels in, bytes out, config write
`default_nettype none

interface qpce_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       last_pixel;

  modport source (output valid, red, green, blue, alpha, last_pixel, input ready);
  modport sink   (input valid, red, green, blue, alpha, last_pixel, output ready);
endinterface

interface qpce_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_item;
  logic       end_of_image;

  modport source (output valid, out_byte, last_of_item, end_of_image, input ready);
  modport sink   (input valid, out_byte, last_of_item, end_of_image, output ready);
endinterface

interface qpce_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] channel_count;

  modport source (output valid, channel_count, input ready);
  modport sink   (input valid, channel_count, output ready);
endinterface

`default_nettype wire

/* design/qoi_pixel_chunk_encoder_core.sv */
// QOI chunk encoder, top level
//
// Pixels enter on pix_i, one RGBA pixel per transfer with a last_pixel flag.
// Encoded chunk bytes leave on byte_o, one byte per transfer, flagged on the
// final byte of each pixel and on the final byte of the image. cfg_i writes
// channel_count (3 forces alpha to 255); it is always ready.
// A pixel is looked up in the color index in the cycle after it is taken,
// then classified into a command that waits in a QUEUE_DEPTH-entry queue;
// the byte sequencer turns each command into 1 to 6 bytes, one byte per
// cycle while the receiver is ready, through the output register. Pixels
// that give zero or one byte go at one per cycle while the receiver is
// ready; a pixel giving more holds the byte port until its last byte is out,
// which sets the rate for LUMA, RGB and RGBA chunks once the queue is full.
// Reset clears the index valid bits at once (no clearing pass), sets the
// previous pixel to opaque black and the run to zero; the same happens after
// the last pixel of an image. A stalled receiver holds the output byte and
// backs up through the queue to pix_i.ready.
`default_nettype none

module qoi_pixel_chunk_encoder_core import qpce_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  qpce_pix_if.sink    pix_i,
  qpce_cfg_if.sink    cfg_i,
  qpce_byte_if.source byte_o
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic head_valid;
  logic head_ready;
  cmd_t head;

  qpce_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_i       (pix_i),
    .cfg_i       (cfg_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  qpce_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cmd_valid),
    .push_ready_o (cmd_ready),
    .push_data_i  (cmd),
    .pop_valid_o  (head_valid),
    .pop_ready_i  (head_ready),
    .pop_data_o   (head)
  );

  qpce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (head_valid),
    .cmd_ready_o (head_ready),
    .cmd_i       (head),
    .byte_o      (byte_o)
  );

endmodule

`default_nettype wire

/* design/qpce_front.sv */
// front end: takes pixels, looks up the color index and classifies each pixel
`default_nettype none

module qpce_front import qpce_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  qpce_pix_if.sink    pix_i,
  qpce_cfg_if.sink    cfg_i,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output cmd_t        cmd_o
);

  logic [2:0] chan_cnt_q;

  logic              s1_valid_q;
  pixel_t            s1_px_q;
  logic [SLOT_W-1:0] s1_slot_q;
  logic              s1_last_q;

  pixel_t                 prev_q;
  logic [5:0]             run_q;
  logic [INDEX_DEPTH-1:0] slot_valid_q;

  pixel_t mem_q [INDEX_DEPTH];
  pixel_t rd_q;

  pixel_t            in_px;
  logic [SLOT_W-1:0] in_slot;
  logic              accept;

  logic              same;
  logic              hit;
  logic              need;
  logic              s1_done;
  logic              wr_en;
  logic [5:0]        run_inc;
  logic [5:0]        run_d;
  logic signed [7:0] vr, vg, vb, vgr, vgb;
  logic              diff_ok;
  logic              luma_ok;
  cmd_t              cmd;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt_q <= CC_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      chan_cnt_q <= cfg_i.channel_count;
    end
  end

  always_comb begin
    in_px.r = pix_i.red;
    in_px.g = pix_i.green;
    in_px.b = pix_i.blue;
    in_px.a = (chan_cnt_q == CC_RGB) ? ALPHA_OPAQUE : pix_i.alpha;
    in_slot = qpce_hash(in_px);
  end

  assign accept = pix_i.valid && pix_i.ready;

  // classification of the pixel held in the lookup stage
  assign same    = (s1_px_q == prev_q);
  assign run_inc = run_q + 6'd1;
  // an unwritten slot reads as zero
  assign hit     = ((slot_valid_q[s1_slot_q] ? rd_q : pixel_t'('0)) == s1_px_q);

  always_comb begin
    vr  = signed'(s1_px_q.r - prev_q.r);
    vg  = signed'(s1_px_q.g - prev_q.g);
    vb  = signed'(s1_px_q.b - prev_q.b);
    vgr = vr - vg;
    vgb = vb - vg;
    diff_ok = (vr >= -8'sd2) && (vr <= 8'sd1) && (vg >= -8'sd2) && (vg <= 8'sd1)
           && (vb >= -8'sd2) && (vb <= 8'sd1);
    luma_ok = (vgr >= -8'sd8) && (vgr <= 8'sd7) && (vg >= -8'sd32) && (vg <= 8'sd31)
           && (vgb >= -8'sd8) && (vgb <= 8'sd7);
  end

  always_comb begin
    cmd           = '0;
    cmd.last      = s1_last_q;
    cmd.chunk_len = LEN_NONE;
    need          = 1'b1;
    run_d         = run_q;
    if (same) begin
      if (run_inc == RUN_MAX || s1_last_q) begin
        cmd.run_valid = 1'b1;
        cmd.run_byte  = OP_RUN | {2'b00, run_q};
        run_d         = 6'd0;
      end else begin
        need  = 1'b0;
        run_d = run_inc;
      end
    end else begin
      run_d = 6'd0;
      if (run_q != 6'd0) begin
        cmd.run_valid = 1'b1;
        cmd.run_byte  = OP_RUN | {2'b00, run_q - 6'd1};
      end
      if (hit) begin
        cmd.chunk_len = LEN_INDEX;
        cmd.chunk[0]  = OP_INDEX | {2'b00, s1_slot_q};
      end else if (s1_px_q.a != prev_q.a) begin
        cmd.chunk_len = LEN_RGBA;
        cmd.chunk[0]  = OP_RGBA;
        cmd.chunk[1]  = s1_px_q.r;
        cmd.chunk[2]  = s1_px_q.g;
        cmd.chunk[3]  = s1_px_q.b;
        cmd.chunk[4]  = s1_px_q.a;
      end else if (diff_ok) begin
        cmd.chunk_len = LEN_DIFF;
        cmd.chunk[0]  = OP_DIFF | {2'b00, 2'(vr + 8'sd2), 2'(vg + 8'sd2), 2'(vb + 8'sd2)};
      end else if (luma_ok) begin
        cmd.chunk_len = LEN_LUMA;
        cmd.chunk[0]  = OP_LUMA | {2'b00, 6'(vg + 8'sd32)};
        cmd.chunk[1]  = {4'(vgr + 8'sd8), 4'(vgb + 8'sd8)};
      end else begin
        cmd.chunk_len = LEN_RGB;
        cmd.chunk[0]  = OP_RGB;
        cmd.chunk[1]  = s1_px_q.r;
        cmd.chunk[2]  = s1_px_q.g;
        cmd.chunk[3]  = s1_px_q.b;
      end
    end
  end

  assign cmd_o       = cmd;
  assign cmd_valid_o = s1_valid_q && need;
  assign s1_done     = s1_valid_q && (!need || cmd_ready_i);
  assign wr_en       = s1_done && !same && !hit;
  assign pix_i.ready = !s1_valid_q || s1_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_done) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q   <= in_px;
      s1_slot_q <= in_slot;
      s1_last_q <= pix_i.last_pixel;
    end
  end

  // end of image puts the index, previous pixel and run back to reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q       <= PREV_RESET;
      run_q        <= 6'd0;
      slot_valid_q <= '0;
    end else if (s1_done) begin
      if (s1_last_q) begin
        prev_q       <= PREV_RESET;
        run_q        <= 6'd0;
        slot_valid_q <= '0;
      end else begin
        prev_q <= s1_px_q;
        run_q  <= run_d;
        if (wr_en) begin
          slot_valid_q[s1_slot_q] <= 1'b1;
        end
      end
    end
  end

  // index memory, read bypasses a write to the same slot in the same cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[s1_slot_q] <= s1_px_q;
    end
    if (accept) begin
      rd_q <= (wr_en && (s1_slot_q == in_slot)) ? s1_px_q : mem_q[in_slot];
    end
  end

  a_run_below_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q < RUN_MAX)
    else $error("run count reached the flush length without a run chunk");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_done && s1_last_q) |=> (run_q == 6'd0) && (prev_q == PREV_RESET)
                               && (slot_valid_q == '0))
    else $error("state not back to reset after the last pixel");

endmodule

`default_nettype wire

/* design/qpce_queue.sv */
// short command queue between the classifier and the byte sequencer
`default_nettype none

module qpce_queue import qpce_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push;
  logic             pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("queue fill count lost a push");

endmodule

`default_nettype wire

/* design/qpce_back.sv */
// back end: walks each command byte by byte into the output register
`default_nettype none

module qpce_back import qpce_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cmd_valid_i,
  output logic         cmd_ready_o,
  input  cmd_t         cmd_i,
  qpce_byte_if.source  byte_o
);

  logic [2:0] pos_q;
  logic [2:0] total;
  logic [2:0] chunk_pos;
  logic       is_end;
  logic       load;
  logic [7:0] byte_sel;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       out_eoi_q;

  assign total     = 3'(cmd_i.run_valid) + cmd_i.chunk_len;
  assign is_end    = (pos_q == total - 3'd1);
  assign chunk_pos = pos_q - {2'b00, cmd_i.run_valid};

  always_comb begin
    if (cmd_i.run_valid && (pos_q == 3'd0)) begin
      byte_sel = cmd_i.run_byte;
    end else begin
      case (chunk_pos)
        3'd0:    byte_sel = cmd_i.chunk[0];
        3'd1:    byte_sel = cmd_i.chunk[1];
        3'd2:    byte_sel = cmd_i.chunk[2];
        3'd3:    byte_sel = cmd_i.chunk[3];
        3'd4:    byte_sel = cmd_i.chunk[4];
        default: byte_sel = 8'h00;
      endcase
    end
  end

  // output register frees up on the same cycle its byte is transferred
  assign load        = cmd_valid_i && (!out_valid_q || byte_o.ready);
  assign cmd_ready_o = load && is_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pos_q       <= 3'd0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        pos_q       <= is_end ? 3'd0 : pos_q + 3'd1;
      end else if (byte_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= byte_sel;
      out_last_q <= is_end;
      out_eoi_q  <= is_end && cmd_i.last;
    end
  end

  assign byte_o.valid        = out_valid_q;
  assign byte_o.out_byte     = out_byte_q;
  assign byte_o.last_of_item = out_last_q;
  assign byte_o.end_of_image = out_eoi_q;

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i |-> pos_q < total)
    else $error("byte position ran past the end of the command");

  a_pop_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_ready_o |=> byte_o.valid && byte_o.last_of_item)
    else $error("command retired without its final byte flagged");

endmodule

`default_nettype wire

/* verif/qoi_pixel_chunk_encoder_core_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench of the qoi chunk encoder: pixels in, chunk bytes checked in order

module qoi_pixel_chunk_encoder_core_tb;
  import qpce_pkg::*;

  localparam logic [2:0] CC_ZERO = 3'd0;
  localparam logic [2:0] CC_MAX  = 3'd7;

  localparam int RANDOM_ITEMS  = 220;
  localparam int SETTLE_CYCLES = 12;
  localparam int END_CYCLES    = 20;
  localparam int HOLD_AT       = 120;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       lo;
    logic       eoi;
  } chunk_byte_t;

  // seq holds up to six bytes, first byte in the top bits
  typedef struct packed {
    logic        cfg_wr;
    logic [2:0]  cfg_val;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
    logic        last;
    logic        typed;
    logic [2:0]  n;
    logic [47:0] seq;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [23] = '{
    // repeat of the reset pixel, then flushed by the last pixel
    '{1'b1, CC_RESET, 8'h00, 8'h00, 8'h00, 8'hff, 1'b0, 1'b1, 3'd0, 48'h0},
    '{1'b0, CC_RESET, 8'h00, 8'h00, 8'h00, 8'hff, 1'b1, 1'b1, 3'd1, 48'hc1_00_00_00_00_00},
    // transparent black hits the zeroed index
    '{1'b0, CC_RESET, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 3'd1, 48'h00_00_00_00_00_00},
    '{1'b0, CC_RESET, 8'h01, 8'h01, 8'h01, 8'h00, 1'b0, 1'b1, 3'd1, 48'h7f_00_00_00_00_00},
    '{1'b0, CC_RESET, 8'hff, 8'hff, 8'hff, 8'h00, 1'b0, 1'b1, 3'd1, 48'h40_00_00_00_00_00},
    '{1'b0, CC_RESET, 8'h1e, 8'h1e, 8'h1e, 8'h00, 1'b0, 1'b1, 3'd2, 48'hbf_88_00_00_00_00},
    '{1'b0, CC_RESET, 8'hf6, 8'hfe, 8'hf6, 8'h00, 1'b0, 1'b1, 3'd2, 48'h80_00_00_00_00_00},
    '{1'b0, CC_RESET, 8'h64, 8'h00, 8'hc8, 8'h00, 1'b0, 1'b1, 3'd4, 48'hfe_64_00_c8_00_00},
    '{1'b0, CC_RESET, 8'h01, 8'h02, 8'h03, 8'h80, 1'b0, 1'b1, 3'd5, 48'hff_01_02_03_80_00},
    '{1'b0, CC_RESET, 8'h64, 8'h00, 8'hc8, 8'h00, 1'b0, 1'b1, 3'd1, 48'h24_00_00_00_00_00},
    '{1'b0, CC_RESET, 8'h64, 8'h00, 8'hc8, 8'h00, 1'b0, 1'b1, 3'd0, 48'h0},
    '{1'b0, CC_RESET, 8'h64, 8'h00, 8'hc8, 8'h00, 1'b0, 1'b1, 3'd0, 48'h0},
    '{1'b0, CC_RESET, 8'h64, 8'h00, 8'hc8, 8'h00, 1'b0, 1'b1, 3'd0, 48'h0},
    '{1'b0, CC_RESET, 8'h01, 8'h02, 8'h03, 8'h80, 1'b0, 1'b1, 3'd2, 48'hc2_22_00_00_00_00},
    // run of one followed by a full rgba chunk: six bytes
    '{1'b0, CC_RESET, 8'h01, 8'h02, 8'h03, 8'h80, 1'b0, 1'b1, 3'd0, 48'h0},
    '{1'b0, CC_RESET, 8'h09, 8'h09, 8'h09, 8'h09, 1'b0, 1'b1, 3'd6, 48'hc0_ff_09_09_09_09},
    '{1'b0, CC_RESET, 8'h09, 8'h09, 8'h09, 8'h09, 1'b1, 1'b1, 3'd1, 48'hc0_00_00_00_00_00},
    // index was cleared by the last pixel
    '{1'b0, CC_RESET, 8'h64, 8'h00, 8'hc8, 8'h00, 1'b0, 1'b1, 3'd5, 48'hff_64_00_c8_00_00},
    '{1'b0, CC_RESET, 8'h00, 8'h00, 8'h00, 8'hff, 1'b1, 1'b1, 3'd5, 48'hff_00_00_00_ff_00},
    // alpha forced opaque, so this matches the reset pixel
    '{1'b1, CC_RGB,   8'h00, 8'h00, 8'h00, 8'h11, 1'b1, 1'b1, 3'd1, 48'hc0_00_00_00_00_00},
    '{1'b0, CC_RGB,   8'h05, 8'h05, 8'h05, 8'h00, 1'b0, 1'b0, 3'd0, 48'h0},
    // register changes mid image
    '{1'b1, CC_MAX,   8'h05, 8'h05, 8'h05, 8'h00, 1'b0, 1'b0, 3'd0, 48'h0},
    '{1'b1, CC_ZERO,  8'h05, 8'h05, 8'h05, 8'h00, 1'b1, 1'b0, 3'd0, 48'h0}
  };

  logic clk;
  logic rst_n;

  qpce_pix_if  pix_if ();
  qpce_cfg_if  cfg_if ();
  qpce_byte_if byte_if ();

  qoi_pixel_chunk_encoder_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pix_i  (pix_if),
    .cfg_i  (cfg_if),
    .byte_o (byte_if)
  );

  // encoder state as seen by the predictor
  pixel_t      color_mem [INDEX_DEPTH];
  pixel_t      prev_px;
  logic [5:0]  run_cnt;
  logic [2:0]  chan_cfg;

  chunk_byte_t pending_bytes [$];
  chunk_byte_t pixel_bytes [$];
  int          errors;
  int          bytes_seen;
  int          tx_calm;
  int          rx_calm;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #(5_000_000);
    $display("qoi_pixel_chunk_encoder_core_tb NOT OK");
    $finish;
  end

  function automatic void clear_codec();
    foreach (color_mem[k]) color_mem[k] = '0;
    prev_px = PREV_RESET;
    run_cnt = '0;
  endfunction

  function automatic void put_byte(logic [7:0] data);
    pixel_bytes.push_back('{data: data, lo: 1'b0, eoi: 1'b0});
  endfunction

  // mostly zero, sometimes short, rarely long; calm stretches have no gaps at all
  function automatic int pick_gap(inout int calm);
    int k;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    k = $urandom_range(0, 99);
    if (k < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (k < 58) return 0;
    if (k < 88) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic void encode_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                       logic [7:0] a_in, logic last);
    pixel_t            px;
    logic [5:0]        slot;
    logic signed [7:0] dr, dg, db, dgr, dgb;
    int                vr, vg, vb, vgr, vgb;
    pixel_bytes.delete();
    px.r = r;
    px.g = g;
    px.b = b;
    px.a = (chan_cfg == CC_RGB) ? ALPHA_OPAQUE : a_in;
    if (px == prev_px) begin
      run_cnt++;
      if (run_cnt >= RUN_MAX || last) begin
        put_byte(OP_RUN | 8'(run_cnt - 6'd1));
        run_cnt = '0;
      end
    end else begin
      if (run_cnt != '0) begin
        put_byte(OP_RUN | 8'(run_cnt - 6'd1));
        run_cnt = '0;
      end
      slot = 6'((int'(px.r) * 3 + int'(px.g) * 5 + int'(px.b) * 7 + int'(px.a) * 11)
                % INDEX_DEPTH);
      if (color_mem[slot] == px) begin
        put_byte(OP_INDEX | 8'(slot));
      end else begin
        color_mem[slot] = px;
        if (px.a == prev_px.a) begin
          dr  = px.r - prev_px.r;
          dg  = px.g - prev_px.g;
          db  = px.b - prev_px.b;
          dgr = dr - dg;
          dgb = db - dg;
          vr  = dr;
          vg  = dg;
          vb  = db;
          vgr = dgr;
          vgb = dgb;
          if (vr >= -2 && vr <= 1 && vg >= -2 && vg <= 1 && vb >= -2 && vb <= 1) begin
            put_byte(OP_DIFF | 8'(((vr + 2) << 4) | ((vg + 2) << 2) | (vb + 2)));
          end else if (vgr >= -8 && vgr <= 7 && vg >= -32 && vg <= 31 &&
                       vgb >= -8 && vgb <= 7) begin
            put_byte(OP_LUMA | 8'(vg + 32));
            put_byte(8'(((vgr + 8) << 4) | (vgb + 8)));
          end else begin
            put_byte(OP_RGB);
            put_byte(px.r);
            put_byte(px.g);
            put_byte(px.b);
          end
        end else begin
          put_byte(OP_RGBA);
          put_byte(px.r);
          put_byte(px.g);
          put_byte(px.b);
          put_byte(px.a);
        end
      end
    end
    prev_px = px;
    if (pixel_bytes.size() != 0) begin
      pixel_bytes[pixel_bytes.size() - 1].lo = 1'b1;
      if (last) pixel_bytes[pixel_bytes.size() - 1].eoi = 1'b1;
    end
    if (last) clear_codec();
  endfunction

  task automatic note_fail(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%s", msg);
  endtask

  // lets the last pixels run through the pipeline with no input offered
  task automatic wait_drained();
    pix_if.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [2:0] val);
    cfg_if.valid         <= 1'b1;
    cfg_if.channel_count <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    chan_cfg = val;
  endtask

  task automatic send_pixel(pixel_t px, logic last, logic typed, logic [2:0] n,
                            logic [47:0] seq);
    int gap;
    pix_if.valid      <= 1'b1;
    pix_if.red        <= px.r;
    pix_if.green      <= px.g;
    pix_if.blue       <= px.b;
    pix_if.alpha      <= px.a;
    pix_if.last_pixel <= last;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    encode_pixel(px.r, px.g, px.b, px.a, last);
    if (typed) begin
      for (int k = 0; k < n; k++) begin
        pending_bytes.push_back('{data: seq[47 - 8 * k -: 8], lo: (k == n - 1),
                                  eoi: last && (k == n - 1)});
      end
    end else begin
      foreach (pixel_bytes[k]) pending_bytes.push_back(pixel_bytes[k]);
    end
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // byte receiver: random stalls plus one long hold-off that backs the block up
  initial begin
    int stall_left;
    chunk_byte_t got;
    chunk_byte_t want;
    stall_left    = 0;
    rx_calm       = 0;
    bytes_seen    = 0;
    byte_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (byte_if.valid && byte_if.ready) begin
        got = '{data: byte_if.out_byte, lo: byte_if.last_of_item, eoi: byte_if.end_of_image};
        if (pending_bytes.size() == 0) begin
          note_fail($sformatf("unexpected byte %0d: %02h lo %0b eoi %0b",
                              bytes_seen, got.data, got.lo, got.eoi));
        end else begin
          want = pending_bytes.pop_front();
          if (got !== want) begin
            note_fail($sformatf("byte %0d: expected %02h lo %0b eoi %0b, got %02h lo %0b eoi %0b",
                                bytes_seen, want.data, want.lo, want.eoi,
                                got.data, got.lo, got.eoi));
          end
        end
        bytes_seen++;
        if (bytes_seen == HOLD_AT) stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        byte_if.ready <= 1'b0;
        stall_left--;
      end else begin
        byte_if.ready <= 1'b1;
        stall_left = pick_gap(rx_calm);
      end
    end
  end

  initial begin
    dir_row_t   row;
    pixel_t     cur;
    pixel_t     hist [16];
    logic [3:0] hist_wr;
    logic [2:0] cfg_val;
    logic       is_last;
    int         run_left;
    int         random_sent;
    int         phase_len;
    int         mode;
    int         dg;

    errors  = 0;
    tx_calm = 0;
    clear_codec();
    chan_cfg = CC_RESET;
    rst_n                <= 1'b0;
    pix_if.valid         <= 1'b0;
    pix_if.red           <= '0;
    pix_if.green         <= '0;
    pix_if.blue          <= '0;
    pix_if.alpha         <= '0;
    pix_if.last_pixel    <= 1'b0;
    cfg_if.valid         <= 1'b0;
    cfg_if.channel_count <= CC_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_TAB[i]) begin
      row = DIR_TAB[i];
      if (row.cfg_wr) begin
        wait_drained();
        write_cfg(row.cfg_val);
      end
      send_pixel('{a: row.a, b: row.b, g: row.g, r: row.r}, row.last, row.typed, row.n,
                 row.seq);
    end

    // random images: runs, small steps, luma steps, revisits and some noise
    cur = PREV_RESET;
    foreach (hist[k]) hist[k] = PREV_RESET;
    hist_wr     = '0;
    run_left    = 63;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      wait_drained();
      case ($urandom_range(0, 5))
        0:       cfg_val = CC_RGB;
        1:       cfg_val = CC_RESET;
        2:       cfg_val = CC_ZERO;
        3:       cfg_val = CC_MAX;
        default: cfg_val = 3'($urandom_range(0, 7));
      endcase
      write_cfg(cfg_val);
      phase_len = $urandom_range(15, 45);
      repeat (phase_len) begin
        if (run_left > 0) begin
          run_left--;
        end else begin
          mode = $urandom_range(0, 99);
          if (mode < 18) begin
            run_left = ($urandom_range(0, 15) == 0) ? $urandom_range(57, 65)
                                                    : $urandom_range(0, 4);
          end else if (mode < 42) begin
            cur.r = cur.r + 8'($urandom_range(0, 3)) - 8'd2;
            cur.g = cur.g + 8'($urandom_range(0, 3)) - 8'd2;
            cur.b = cur.b + 8'($urandom_range(0, 3)) - 8'd2;
          end else if (mode < 62) begin
            dg    = int'($urandom_range(0, 63)) - 32;
            cur.g = cur.g + 8'(dg);
            cur.r = cur.r + 8'(dg + int'($urandom_range(0, 15)) - 8);
            cur.b = cur.b + 8'(dg + int'($urandom_range(0, 15)) - 8);
          end else if (mode < 78) begin
            cur = hist[$urandom_range(0, 15)];
          end else if (mode < 94) begin
            {cur.b, cur.g, cur.r} = 24'($urandom);
          end else begin
            cur = pixel_t'($urandom);
          end
        end
        hist[hist_wr] = cur;
        hist_wr++;
        is_last = ($urandom_range(0, 27) == 0);
        send_pixel(cur, is_last, 1'b0, 3'd0, 48'h0);
        random_sent++;
      end
    end

    pix_if.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("qoi_pixel_chunk_encoder_core_tb OK");
    end else begin
      $display("qoi_pixel_chunk_encoder_core_tb NOT OK");
    end
    $finish;
  end

endmodule
